FILE: sv/npcs_pkg.sv
// shared constants, types and codes for the nearest palette colour search
// no dependencies

package npcs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int ADDR_W          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int LAST_ENTRY      = PALETTE_ENTRIES - 1;

  localparam int IDX_W    = 8;
  localparam int COMP_W   = 8;
  localparam int COLOUR_W = 3 * COMP_W;
  localparam int SQ_W     = 2 * COMP_W;
  localparam int DIST_W   = SQ_W + 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } npcs_op_t;

  // tag that travels with each palette read through the distance pipeline
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } npcs_tag_t;

endpackage

FILE: sv/npcs_palette_ram.sv
// palette store: one write port, one read port, registered read data
// depends on npcs_pkg

module npcs_palette_ram (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [npcs_pkg::ADDR_W-1:0]         wr_addr,
  input  logic [npcs_pkg::COLOUR_W-1:0]       wr_data,
  input  logic                                rd_en,
  input  logic [npcs_pkg::ADDR_W-1:0]         rd_addr,
  output logic [npcs_pkg::COLOUR_W-1:0]       rd_data
);

  logic [npcs_pkg::COLOUR_W-1:0] mem [npcs_pkg::PALETTE_ENTRIES];
  logic [npcs_pkg::COLOUR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/npcs_dist.sv
// three-stage squared rgb distance pipeline: abs diff, square, sum
// depends on npcs_pkg

module npcs_dist (
  input  logic                              clk,
  input  logic                              rst_n,
  input  npcs_pkg::npcs_tag_t               tag_in,
  input  logic [npcs_pkg::COLOUR_W-1:0]     entry,
  input  logic [npcs_pkg::COMP_W-1:0]       q_red,
  input  logic [npcs_pkg::COMP_W-1:0]       q_green,
  input  logic [npcs_pkg::COMP_W-1:0]       q_blue,
  output npcs_pkg::npcs_tag_t               tag_out,
  output logic [npcs_pkg::DIST_W-1:0]       sq_dist
);

  localparam int CW = npcs_pkg::COMP_W;

  npcs_pkg::npcs_tag_t       tag1_r, tag2_r, tag3_r;
  logic [CW-1:0]             dr_r, dg_r, db_r;
  logic [npcs_pkg::SQ_W-1:0] sr_r, sg_r, sb_r;
  logic [npcs_pkg::DIST_W-1:0] dist_r;

  logic [CW-1:0] e_r, e_g, e_b;
  logic [CW-1:0] dr_nxt, dg_nxt, db_nxt;

  always_comb begin
    e_r    = entry[3*CW-1:2*CW];
    e_g    = entry[2*CW-1:CW];
    e_b    = entry[CW-1:0];
    dr_nxt = (q_red   >= e_r) ? (q_red   - e_r) : (e_r - q_red);
    dg_nxt = (q_green >= e_g) ? (q_green - e_g) : (e_g - q_green);
    db_nxt = (q_blue  >= e_b) ? (q_blue  - e_b) : (e_b - q_blue);
  end

  // control: tag valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    dr_r   <= dr_nxt;
    dg_r   <= dg_nxt;
    db_r   <= db_nxt;
    sr_r   <= npcs_pkg::SQ_W'(dr_r) * npcs_pkg::SQ_W'(dr_r);
    sg_r   <= npcs_pkg::SQ_W'(dg_r) * npcs_pkg::SQ_W'(dg_r);
    sb_r   <= npcs_pkg::SQ_W'(db_r) * npcs_pkg::SQ_W'(db_r);
    dist_r <= npcs_pkg::DIST_W'(sr_r) + npcs_pkg::DIST_W'(sg_r) + npcs_pkg::DIST_W'(sb_r);
  end

  assign tag_out = tag3_r;
  assign sq_dist = dist_r;

endmodule

FILE: sv/nearest_palette_colour_search.sv
// nearest palette colour search, top level; holds palette ram, distance pipe, sequencer
// a load is written on acceptance; a query with source index 0 goes straight to finish, no search
// query with nonzero index: scans entries 1..PALETTE_ENTRIES-1, drains the pipe, then finishes
// throughput: one transaction at a time; a nonzero query holds the block through its scan,
// one palette read per cycle over entries 1..PALETTE_ENTRIES-1, the pipe drain and finish
// reset clears the sequencer, the read and pipe tags and output valid, not the payload

module nearest_palette_colour_search (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [npcs_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [npcs_pkg::COMP_W-1:0]   in_red,
  input  logic [npcs_pkg::COMP_W-1:0]   in_green,
  input  logic [npcs_pkg::COMP_W-1:0]   in_blue,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [npcs_pkg::IDX_W-1:0]    out_source_index,
  output logic [npcs_pkg::IDX_W-1:0]    out_best_index
);

  localparam int AW = npcs_pkg::ADDR_W;
  localparam int DW = npcs_pkg::DIST_W;

  // sequencer: idle takes any transaction, scan issues palette reads,
  // drain waits for the pipe to empty, finish hands the result to the output register
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                         state_r, state_nxt;
  logic [AW-1:0]                  scan_addr_r, scan_addr_nxt;
  npcs_pkg::npcs_tag_t            rd_tag_r, rd_tag_nxt;
  logic [AW-1:0]                  best_r, best_nxt;
  logic [DW-1:0]                  best_dist_r, best_dist_nxt;
  logic [npcs_pkg::IDX_W-1:0]     src_r, src_nxt;
  logic [npcs_pkg::COMP_W-1:0]    q_red_r, q_red_nxt;
  logic [npcs_pkg::COMP_W-1:0]    q_green_r, q_green_nxt;
  logic [npcs_pkg::COMP_W-1:0]    q_blue_r, q_blue_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [npcs_pkg::IDX_W-1:0]     out_src_r, out_src_nxt;
  logic [npcs_pkg::IDX_W-1:0]     out_best_r, out_best_nxt;

  logic                           in_xact;
  logic                           load_in_range;
  logic                           wr_en;
  logic                           rd_en;
  logic                           scan_last;
  logic [npcs_pkg::COLOUR_W-1:0]  rd_data;
  npcs_pkg::npcs_tag_t            dist_tag;
  logic [DW-1:0]                  cand_dist;
  logic                           cand_better;
  logic                           out_free;

  // ---------------------------------------------------------------------------
  // handshake and palette writes
  // ---------------------------------------------------------------------------
  assign in_ready = (state_r == ST_IDLE);
  assign in_xact  = in_valid && in_ready;

  // loads past the palette are dropped
  assign load_in_range = ({1'b0, in_entry_index} < 9'(npcs_pkg::PALETTE_ENTRIES));
  assign wr_en = in_xact && (in_operation == npcs_pkg::OP_LOAD) && load_in_range;

  // reads only happen in scan, writes only in idle, so no same-entry overlap
  assign rd_en     = (state_r == ST_SCAN);
  assign scan_last = (scan_addr_r == AW'(npcs_pkg::LAST_ENTRY));

  npcs_palette_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_entry_index[AW-1:0]),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_en   (rd_en),
    .rd_addr (scan_addr_r),
    .rd_data (rd_data)
  );

  npcs_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (rd_tag_r),
    .entry   (rd_data),
    .q_red   (q_red_r),
    .q_green (q_green_r),
    .q_blue  (q_blue_r),
    .tag_out (dist_tag),
    .sq_dist (cand_dist)
  );

  // strict less-than keeps the lowest index on a tie
  assign cand_better = dist_tag.vld && (cand_dist < best_dist_r);
  assign out_free    = !out_valid_r || out_ready;

  // ---------------------------------------------------------------------------
  // next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    scan_addr_nxt = scan_addr_r;
    best_nxt      = best_r;
    best_dist_nxt = best_dist_r;
    src_nxt       = src_r;
    q_red_nxt     = q_red_r;
    q_green_nxt   = q_green_r;
    q_blue_nxt    = q_blue_r;
    out_src_nxt   = out_src_r;
    out_best_nxt  = out_best_r;

    // read tag is registered alongside the ram read data
    rd_tag_nxt.vld  = rd_en;
    rd_tag_nxt.last = scan_last;
    rd_tag_nxt.idx  = scan_addr_r;

    // output register drops on transaction, reloaded below in finish
    out_valid_nxt = out_valid_r && !out_ready;

    // running minimum over the distance pipe output
    if (cand_better) begin
      best_nxt      = dist_tag.idx;
      best_dist_nxt = cand_dist;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xact && (in_operation == npcs_pkg::OP_QUERY)) begin
          src_nxt       = in_entry_index;
          q_red_nxt     = in_red;
          q_green_nxt   = in_green;
          q_blue_nxt    = in_blue;
          scan_addr_nxt = AW'(1);
          best_dist_nxt = '1;
          if (in_entry_index == '0) begin
            // transparent entry maps to itself, no search
            best_nxt  = '0;
            state_nxt = ST_FINISH;
          end else begin
            best_nxt  = AW'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_addr_nxt = scan_addr_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (dist_tag.vld && dist_tag.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_src_nxt   = src_r;
          out_best_nxt  = npcs_pkg::IDX_W'(best_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // state and registered outputs
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_tag_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_tag_r    <= rd_tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    best_r      <= best_nxt;
    best_dist_r <= best_dist_nxt;
    src_r       <= src_nxt;
    q_red_r     <= q_red_nxt;
    q_green_r   <= q_green_nxt;
    q_blue_r    <= q_blue_nxt;
    out_src_r   <= out_src_nxt;
    out_best_r  <= out_best_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_source_index = out_src_r;
  assign out_best_index   = out_best_r;

endmodule

FILE: sv/npcs_checker.sv
// port-level checks for the nearest palette colour search, bound to the top level
// depends on npcs_pkg and nearest_palette_colour_search

module npcs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [npcs_pkg::IDX_W-1:0]    out_source_index,
  input logic [npcs_pkg::IDX_W-1:0]    out_best_index
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_source_index) && $stable(out_best_index))
    else $error("result payload changed while stalled");

  // transparent source maps to entry zero
  a_zero_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_source_index == '0) |-> (out_best_index == '0))
    else $error("source index zero not mapped to zero");

  // entry zero is never a search winner
  a_no_zero_win: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_source_index != '0) |-> (out_best_index != '0))
    else $error("search returned the reserved entry");

  // a query holds off the next transaction while it runs
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == npcs_pkg::OP_QUERY) |=> !in_ready)
    else $error("input taken during a query");

endmodule

bind nearest_palette_colour_search npcs_checker u_npcs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_operation     (in_operation),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_source_index (out_source_index),
  .out_best_index   (out_best_index)
);

FILE: verif/nearest_palette_colour_search_test.sv
// testbench for nearest_palette_colour_search: loads the target palette, runs directed and
// random load and query traffic with random idling on both channels, checks every result transaction
// depends on npcs_pkg and the nearest_palette_colour_search rtl
`timescale 1ns / 1ps

module nearest_palette_colour_search_test;

  localparam int CLK_PERIOD = 10;
  // overall run limit, well above the slowest legal run
  localparam int RUN_LIMIT_NS = 60_000_000;
  // drain window after the last result
  localparam int DRAIN_CYCLES = npcs_pkg::PALETTE_ENTRIES + 40;
  localparam int RANDOM_ITEMS = 950;
  localparam int MAX_REPORTS = 10;

  localparam int IW = npcs_pkg::IDX_W;
  localparam int CW = npcs_pkg::COMP_W;
  localparam int NE = npcs_pkg::PALETTE_ENTRIES;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_operation;
  logic [IW-1:0]       in_entry_index;
  logic [CW-1:0]       in_red;
  logic [CW-1:0]       in_green;
  logic [CW-1:0]       in_blue;
  logic                out_valid;
  logic                out_ready;
  logic [IW-1:0]       out_source_index;
  logic [IW-1:0]       out_best_index;

  // one expected result transaction
  typedef struct {
    logic [IW-1:0] src;
    logic [IW-1:0] best;
  } match_t;

  // our own copy of the target palette, red in 23..16, green in 15..8, blue in 7..0
  logic [npcs_pkg::COLOUR_W-1:0] shadow_palette [NE];
  match_t              match_q [$];
  int                  mismatches;

  // idling controls shared between the test tasks and the result sink
  bit                  tx_steady;
  bit                  sink_steady;
  int                  sink_hold;

  nearest_palette_colour_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_entry_index   (in_entry_index),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_source_index (out_source_index),
    .out_best_index   (out_best_index)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // least squared rgb distance over entries 1..last, lowest index wins a tie,
  // entry 0 is the transparent slot and never a candidate
  function automatic logic [IW-1:0] nearest_target(input logic [CW-1:0] r,
                                                   input logic [CW-1:0] g,
                                                   input logic [CW-1:0] b);
    int unsigned      best_dist;
    int unsigned      cand_dist;
    int               dr;
    int               dg;
    int               db;
    logic [IW-1:0]    best;
    best      = IW'(1);
    best_dist = 32'hFFFF_FFFF;
    for (int j = 1; j < NE; j++) begin
      dr        = int'(r) - int'(shadow_palette[j][23:16]);
      dg        = int'(g) - int'(shadow_palette[j][15:8]);
      db        = int'(b) - int'(shadow_palette[j][7:0]);
      cand_dist = dr * dr + dg * dg + db * db;
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best      = IW'(j);
      end
    end
    return best;
  endfunction

  // every accepted input transaction updates the palette copy or queues a match
  always @(posedge clk) begin : input_monitor
    match_t m;
    if (rst_n && in_valid && in_ready) begin
      if (in_operation == npcs_pkg::OP_QUERY) begin
        m.src  = in_entry_index;
        // source index 0 maps straight to the transparent entry
        m.best = (in_entry_index == '0) ? '0 : nearest_target(in_red, in_green, in_blue);
        match_q.push_back(m);
      end else if (int'(in_entry_index) < NE) begin
        shadow_palette[in_entry_index] = {in_red, in_green, in_blue};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : result_checker
    match_t want;
    if (rst_n && out_valid && out_ready) begin
      if (match_q.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: source %0d best %0d",
                                out_source_index, out_best_index));
      end else begin
        want = match_q.pop_front();
        if (out_source_index !== want.src)
          note_mismatch($sformatf("source_index expected %0d actual %0d",
                                  want.src, out_source_index));
        if (out_best_index !== want.best)
          note_mismatch($sformatf("best_index expected %0d actual %0d (source %0d)",
                                  want.best, out_best_index, want.src));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random stalls, steady stretches, and long hold-offs on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int run;
    out_ready = 1'b0;
    forever begin
      if (sink_hold > 0) begin
        // long hold-off, counted here so the sender keeps offering meanwhile
        run       = sink_hold;
        sink_hold = 0;
        repeat (run) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else if (sink_steady || $urandom_range(0, 99) < 75) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        // mostly short stalls, now and then a long one
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
        repeat (run) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // present one transaction at the falling edge and hold it until accepted
  task automatic send_item(input npcs_pkg::npcs_op_t op, input logic [IW-1:0] idx,
                           input logic [CW-1:0] r, input logic [CW-1:0] g,
                           input logic [CW-1:0] b);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_entry_index <= idx;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // gap length: usually none or short, rarely long enough to cover a whole search
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_steady || roll < 70) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic logic [CW-1:0] rand_comp();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return CW'($urandom_range(0, 255));
  endfunction

  // component a few steps away from c, clamped to the field range
  function automatic logic [CW-1:0] near_comp(input logic [CW-1:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CW'(v);
  endfunction

  task automatic wait_drained();
    while (match_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // every entry gets written before any search can read it
  task automatic test_palette_fill();
    for (int j = 0; j < NE; j++) begin
      send_item(npcs_pkg::OP_LOAD, IW'(j), rand_comp(), rand_comp(), rand_comp());
      sender_gap(pick_gap());
    end
  endtask

  // black, white and corner colours, plus source index 0 at both extremes
  task automatic test_colour_extremes();
    send_item(npcs_pkg::OP_LOAD, 8'd1, 8'd0, 8'd0, 8'd0);
    send_item(npcs_pkg::OP_LOAD, 8'd255, 8'd255, 8'd255, 8'd255);
    send_item(npcs_pkg::OP_LOAD, 8'd128, 8'd255, 8'd0, 8'd255);
    send_item(npcs_pkg::OP_QUERY, 8'd255, 8'd255, 8'd255, 8'd255);
    send_item(npcs_pkg::OP_QUERY, 8'd1, 8'd0, 8'd0, 8'd0);
    send_item(npcs_pkg::OP_QUERY, 8'd128, 8'd255, 8'd0, 8'd255);
    send_item(npcs_pkg::OP_QUERY, 8'd200, 8'd0, 8'd255, 8'd0);
    send_item(npcs_pkg::OP_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
    send_item(npcs_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  // entry 0 holds an exact match but must never be picked by a search
  task automatic test_transparent_entry();
    send_item(npcs_pkg::OP_LOAD, 8'd0, 8'd17, 8'd201, 8'd93);
    send_item(npcs_pkg::OP_QUERY, 8'd9, 8'd17, 8'd201, 8'd93);
    send_item(npcs_pkg::OP_QUERY, 8'd0, 8'd17, 8'd201, 8'd93);
  endtask

  // equal distances: duplicated colour, and two entries either side of the query
  task automatic test_tie_break();
    send_item(npcs_pkg::OP_LOAD, 8'd200, 8'd123, 8'd45, 8'd67);
    send_item(npcs_pkg::OP_LOAD, 8'd40, 8'd123, 8'd45, 8'd67);
    send_item(npcs_pkg::OP_QUERY, 8'd77, 8'd123, 8'd45, 8'd67);
    send_item(npcs_pkg::OP_LOAD, 8'd11, 8'd90, 8'd90, 8'd92);
    send_item(npcs_pkg::OP_LOAD, 8'd10, 8'd90, 8'd90, 8'd88);
    send_item(npcs_pkg::OP_QUERY, 8'd5, 8'd90, 8'd90, 8'd90);
  endtask

  // sink holds off for a long stretch while queries keep coming, then the
  // sender pauses until everything is back
  task automatic test_backpressure();
    sink_hold = 2000;
    for (int i = 0; i < 8; i++)
      send_item(npcs_pkg::OP_QUERY, IW'($urandom_range(0, 255)), rand_comp(), rand_comp(),
                rand_comp());
    sender_gap(1);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int               roll;
    logic [IW-1:0]    pick;
    logic [CW-1:0]    r;
    logic [CW-1:0]    g;
    logic [CW-1:0]    b;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // switch between idling and steady stretches now and then
      if (i % 150 == 0) begin
        tx_steady   = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      pick = IW'($urandom_range(1, NE - 1));
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 55) begin
        // load; a fifth copy an existing colour so ties keep turning up
        if (roll < 20) begin
          {r, g, b} = shadow_palette[pick];
        end else begin
          r = rand_comp();
          g = rand_comp();
          b = rand_comp();
        end
        send_item(npcs_pkg::OP_LOAD, IW'($urandom_range(0, 255)), r, g, b);
      end else begin
        // query: exact hits, near misses and free colours
        if (roll < 25) begin
          {r, g, b} = shadow_palette[pick];
        end else if (roll < 40) begin
          r = near_comp(shadow_palette[pick][23:16]);
          g = near_comp(shadow_palette[pick][15:8]);
          b = near_comp(shadow_palette[pick][7:0]);
        end else begin
          r = rand_comp();
          g = rand_comp();
          b = rand_comp();
        end
        send_item(npcs_pkg::OP_QUERY,
                  ($urandom_range(0, 19) == 0) ? '0 : IW'($urandom_range(0, 255)),
                  r, g, b);
      end
      sender_gap(pick_gap());
    end
    tx_steady   = 1'b0;
    sink_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    mismatches     = 0;
    tx_steady      = 1'b0;
    sink_steady    = 1'b0;
    sink_hold      = 0;
    in_valid       = 1'b0;
    in_operation   = npcs_pkg::OP_LOAD;
    in_entry_index = '0;
    in_red         = '0;
    in_green       = '0;
    in_blue        = '0;
    for (int j = 0; j < NE; j++) shadow_palette[j] = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_palette_fill();
    test_colour_extremes();
    test_transparent_entry();
    test_tie_break();
    test_backpressure();
    test_random_traffic();

    sender_gap(1);
    wait_drained();
    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && match_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
